// ===== rtl/core/random_walk_window_pan_macros.svh =====
// Assertion macros shared by the random walk window pan RTL.
`ifndef RANDOM_WALK_WINDOW_PAN_MACROS_SVH
`define RANDOM_WALK_WINDOW_PAN_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked at every rising edge outside reset.
`define RWWP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked at every rising edge outside reset.
`define RWWP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RWWP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define RWWP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/rwwp_pkg.sv =====
// Shared constants, types and helper functions of the window pan block.
package rwwp_pkg;

  // Field widths.
  localparam int MAX_DIM    = 4096;
  localparam int OFFS_W     = 12;
  localparam int IMG_W      = 13;
  localparam int SPEED_W    = 8;
  localparam int ADDR_W     = 32;
  localparam int RAND_W     = 28;
  localparam int DIR_W      = 3;
  localparam int STEP_W     = 10;
  localparam int CFG_IDX_W  = 3;

  // Serial divider sizing.
  localparam int DIVD_W     = RAND_W;
  localparam int DSOR_W     = IMG_W;
  localparam int DCNT_W     = $clog2(DIVD_W + 1);

  // Walk constants.
  localparam int MOD_STEER   = 3;
  localparam int Q_SHIFT     = 8;
  localparam int SPEED_FLOOR = 10;
  localparam int DIV_SHIFT   = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_SPEED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 3'd5;

  // Register reset values.
  localparam logic [IMG_W-1:0]   IMAGE_WIDTH_RST   = 13'd1920;
  localparam logic [IMG_W-1:0]   IMAGE_HEIGHT_RST  = 13'd1080;
  localparam logic [OFFS_W-1:0]  WINDOW_WIDTH_RST  = 12'd800;
  localparam logic [OFFS_W-1:0]  WINDOW_HEIGHT_RST = 12'd480;
  localparam logic [SPEED_W-1:0] MOVE_SPEED_RST    = 8'd1;
  localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST  = 32'd0;

  // Item modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // Headings, clockwise from up.
  localparam logic [DIR_W-1:0] DIR_N    = 3'd0;
  localparam logic [DIR_W-1:0] DIR_NE   = 3'd1;
  localparam logic [DIR_W-1:0] DIR_E    = 3'd2;
  localparam logic [DIR_W-1:0] DIR_SE   = 3'd3;
  localparam logic [DIR_W-1:0] DIR_S    = 3'd4;
  localparam logic [DIR_W-1:0] DIR_SW   = 3'd5;
  localparam logic [DIR_W-1:0] DIR_WEST = 3'd6;
  localparam logic [DIR_W-1:0] DIR_NW   = 3'd7;

  // Channel payloads.
  typedef struct packed {
    logic              mode;
    logic [RAND_W-1:0] random_word;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] window_address;
    logic [OFFS_W-1:0] window_x;
    logic [OFFS_W-1:0] window_y;
    logic [DIR_W-1:0]  heading;
    logic              edge_hit;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    value;
  } cfg_item_t;

  // Request to the serial divider.
  typedef struct packed {
    logic              start;
    logic [DCNT_W-1:0] steps;
  } div_req_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE, S_MOD3, S_SPDIV, S_QMOD, S_STEER, S_MOVE, S_ADDR, S_DONE
  } state_t;

  // Free travel of the window on one axis, saturated to the offset range.
  function automatic logic [OFFS_W-1:0] travel(input logic [IMG_W-1:0] img,
                                               input logic [OFFS_W-1:0] win);
    logic [IMG_W-1:0] d;
    d = (img > IMG_W'(win)) ? img - IMG_W'(win) : '0;
    return (d > IMG_W'(MAX_DIM - 1)) ? OFFS_W'(MAX_DIM - 1) : d[OFFS_W-1:0];
  endfunction

  // Centered offset on one axis, held within the free travel.
  function automatic logic [OFFS_W-1:0] center(input logic [IMG_W-1:0] img,
                                               input logic [OFFS_W-1:0] win,
                                               input logic [OFFS_W-1:0] lim);
    logic [IMG_W-1:0] d;
    d = (img > IMG_W'(win)) ? (img - IMG_W'(win)) >> 1 : '0;
    return (d > IMG_W'(lim)) ? lim : d[OFFS_W-1:0];
  endfunction

endpackage

// ===== rtl/core/rwwp_stream_if.sv =====
// Valid/ready channel carrying one payload item per handshake.
interface rwwp_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rwwp_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
module rwwp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  rwwp_pkg::div_req_t            req,
  input  logic [rwwp_pkg::DIVD_W-1:0]   dividend,
  input  logic [rwwp_pkg::DSOR_W-1:0]   divisor,
  output logic                          done,
  output logic [rwwp_pkg::DIVD_W-1:0]   quot,
  output logic [rwwp_pkg::DSOR_W-1:0]   rem
);
  import rwwp_pkg::*;

  logic [DIVD_W-1:0] dsr;
  logic [DSOR_W-1:0] rem_q;
  logic [DSOR_W-1:0] dsor;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done_q;
  logic [DSOR_W:0]   trial;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign trial = {rem_q, dsr[DIVD_W-1]} - {1'b0, dsor};

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dsr   <= dividend;
      rem_q <= '0;
      dsor  <= divisor;
    end else if (busy) begin
      if (!trial[DSOR_W]) begin
        rem_q <= trial[DSOR_W-1:0];
        dsr   <= {dsr[DIVD_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DSOR_W-2:0], dsr[DIVD_W-1]};
        dsr   <= {dsr[DIVD_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_q;
  assign quot = dsr;
  assign rem  = rem_q;

endmodule

// ===== rtl/core/rwwp_addr.sv =====
// Serial shift-and-add address unit: base + (y * width + x) * 4.
module rwwp_addr (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rwwp_pkg::OFFS_W-1:0]  x,
  input  logic [rwwp_pkg::OFFS_W-1:0]  y,
  input  logic [rwwp_pkg::IMG_W-1:0]   img_width,
  input  logic [rwwp_pkg::ADDR_W-1:0]  base,
  output logic                         done,
  output logic [rwwp_pkg::ADDR_W-1:0]  addr
);
  import rwwp_pkg::*;

  localparam int CNT_W = $clog2(OFFS_W + 1);

  logic [ADDR_W-1:0] acc;
  logic [ADDR_W-1:0] mcand;
  logic [OFFS_W-1:0] ybits;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done_q;

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(OFFS_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // One bit of y per cycle, LSB first, adds the shifted row pitch.
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= base + ADDR_W'({x, 2'b00});
      mcand <= ADDR_W'({img_width, 2'b00});
      ybits <= y;
    end else if (busy) begin
      if (ybits[0]) begin
        acc <= acc + mcand;
      end
      mcand <= {mcand[ADDR_W-2:0], 1'b0};
      ybits <= ybits >> 1;
    end
  end

  assign done = done_q;
  assign addr = acc;

endmodule

// ===== rtl/core/random_walk_window_pan.sv =====
// Random walk window pan: each item is either a start, which centers the
// window and draws a heading, or a vsync tick, which moves the window by
// move_speed pixels along its heading, clamps it at the image edges and
// reflects the heading there; every item yields one result with the window's
// byte address and position. Items are handled one at a time. A start and
// a tick that keeps its heading both wait on the 12-step serial multiply in
// the address unit. A tick whose step count has run out first runs the
// shared bit-serial divider up to three times in a row: 28 steps for the
// steering remainder, 13 for the width over speed and 20 for the new step
// count. A finished result sits in an output register, so the next item is
// taken while it waits.
`include "random_walk_window_pan_macros.svh"

module random_walk_window_pan (
  input  logic          clk,
  input  logic          rst,
  rwwp_stream_if.sink   req,
  rwwp_stream_if.source rsp,
  rwwp_stream_if.sink   cfg
);
  import rwwp_pkg::*;

  localparam int MOV_W = OFFS_W + 2;

  // Configuration registers.
  logic [IMG_W-1:0]   image_width;
  logic [IMG_W-1:0]   image_height;
  logic [OFFS_W-1:0]  window_width;
  logic [OFFS_W-1:0]  window_height;
  logic [SPEED_W-1:0] move_speed;
  logic [ADDR_W-1:0]  base_address;

  // Walk state.
  logic [OFFS_W-1:0]  offset_x;
  logic [OFFS_W-1:0]  offset_y;
  logic [DIR_W-1:0]   direction;
  logic [STEP_W-1:0]  steps_left;
  logic               bounce_parity;
  logic               hit;

  // Sequencer and working registers.
  state_t             state;
  state_t             state_next;
  logic               issued;
  logic               issued_next;
  logic [RAND_W-1:0]  rand_q;
  logic [1:0]         rm3;
  logic [STEP_W-1:0]  div_q;
  logic [STEP_W-1:0]  cnt_q;

  // Shared units.
  div_req_t           div_req;
  logic [DIVD_W-1:0]  div_dividend;
  logic [DSOR_W-1:0]  div_divisor;
  logic               div_done;
  logic [DIVD_W-1:0]  div_quot;
  logic [DSOR_W-1:0]  div_rem;
  logic               addr_start;
  logic               addr_done;
  logic [ADDR_W-1:0]  addr_value;

  // Derived limits and per-step values.
  logic [OFFS_W-1:0]  lim_x;
  logic [OFFS_W-1:0]  lim_y;
  logic [OFFS_W-1:0]  ctr_x;
  logic [OFFS_W-1:0]  ctr_y;
  logic [STEP_W-1:0]  floor_cnt;
  logic [STEP_W-1:0]  new_cnt;
  logic [OFFS_W-1:0]  mv_x;
  logic [OFFS_W-1:0]  mv_y;
  logic [DIR_W-1:0]   mv_dir;
  logic               mv_hit;

  // Output register.
  logic               rsp_valid;
  out_item_t          rsp_data;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMAGE_WIDTH_RST;
      image_height  <= IMAGE_HEIGHT_RST;
      window_width  <= WINDOW_WIDTH_RST;
      window_height <= WINDOW_HEIGHT_RST;
      move_speed    <= MOVE_SPEED_RST;
      base_address  <= BASE_ADDRESS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_IMAGE_WIDTH:   image_width   <= cfg.data.value[IMG_W-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg.data.value[IMG_W-1:0];
        REG_WINDOW_WIDTH:  window_width  <= cfg.data.value[OFFS_W-1:0];
        REG_WINDOW_HEIGHT: window_height <= cfg.data.value[OFFS_W-1:0];
        REG_MOVE_SPEED:    move_speed    <= cfg.data.value[SPEED_W-1:0];
        REG_BASE_ADDRESS:  base_address  <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // Limits of travel and the centered start position.
  assign lim_x = travel(image_width, window_width);
  assign lim_y = travel(image_height, window_height);
  assign ctr_x = center(image_width, window_width, lim_x);
  assign ctr_y = center(image_height, window_height, lim_y);

  // New step count: at least one, then at least min(speed, 10).
  always_comb begin
    logic [STEP_W-1:0] c1;
    floor_cnt = (move_speed > SPEED_W'(SPEED_FLOOR)) ? STEP_W'(SPEED_FLOOR)
                                                     : STEP_W'(move_speed);
    c1        = (cnt_q == '0) ? STEP_W'(1) : cnt_q;
    new_cnt   = (c1 < floor_cnt) ? floor_cnt : c1;
  end

  // One move along the heading, then clamping and reflection in the order
  // left, top, right, bottom, each seeing the heading left by the one before.
  always_comb begin
    logic signed [MOV_W-1:0] px;
    logic signed [MOV_W-1:0] py;
    logic signed [MOV_W-1:0] sp;
    logic [DIR_W-1:0]        d;
    logic                    h;
    d  = direction;
    h  = 1'b0;
    sp = $signed(MOV_W'(move_speed));
    px = $signed(MOV_W'(offset_x));
    py = $signed(MOV_W'(offset_y));
    if (d == DIR_N || d == DIR_NE || d == DIR_NW) begin
      py = py - sp;
    end else if (d == DIR_SE || d == DIR_S || d == DIR_SW) begin
      py = py + sp;
    end
    if (d == DIR_NE || d == DIR_E || d == DIR_SE) begin
      px = px + sp;
    end else if (d == DIR_SW || d == DIR_WEST || d == DIR_NW) begin
      px = px - sp;
    end
    if (px < 0) begin
      px = '0;
      h  = 1'b1;
      if (d == DIR_NW) d = DIR_N;
      else if (d == DIR_SW) d = DIR_S;
      else if (d == DIR_WEST) d = bounce_parity ? DIR_N : DIR_S;
    end
    if (py < 0) begin
      py = '0;
      h  = 1'b1;
      if (d == DIR_NE) d = DIR_E;
      else if (d == DIR_NW) d = DIR_WEST;
      else if (d == DIR_N) d = bounce_parity ? DIR_E : DIR_WEST;
    end
    if (px > $signed(MOV_W'(lim_x))) begin
      px = $signed(MOV_W'(lim_x));
      h  = 1'b1;
      if (d == DIR_SE) d = DIR_S;
      else if (d == DIR_NE) d = DIR_N;
      else if (d == DIR_E) d = bounce_parity ? DIR_S : DIR_N;
    end
    if (py > $signed(MOV_W'(lim_y))) begin
      py = $signed(MOV_W'(lim_y));
      h  = 1'b1;
      if (d == DIR_SW) d = DIR_WEST;
      else if (d == DIR_SE) d = DIR_E;
      else if (d == DIR_S) d = bounce_parity ? DIR_WEST : DIR_E;
    end
    mv_x   = px[OFFS_W-1:0];
    mv_y   = py[OFFS_W-1:0];
    mv_dir = d;
    mv_hit = h;
  end

  // Divider launch and operands for the step in progress.
  always_comb begin
    div_req.start = (state == S_MOD3 || state == S_SPDIV || state == S_QMOD) && !issued;
    case (state)
      S_SPDIV: begin
        div_dividend  = {image_width, {(DIVD_W - IMG_W){1'b0}}};
        div_divisor   = DSOR_W'(move_speed);
        div_req.steps = DCNT_W'(IMG_W);
      end
      S_QMOD: begin
        div_dividend  = {rand_q[RAND_W-1:Q_SHIFT], {Q_SHIFT{1'b0}}};
        div_divisor   = DSOR_W'(div_q);
        div_req.steps = DCNT_W'(RAND_W - Q_SHIFT);
      end
      default: begin
        div_dividend  = rand_q;
        div_divisor   = DSOR_W'(MOD_STEER);
        div_req.steps = DCNT_W'(RAND_W);
      end
    endcase
  end

  rwwp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  rwwp_addr u_addr (
    .clk       (clk),
    .rst       (rst),
    .start     (addr_start),
    .x         (offset_x),
    .y         (offset_y),
    .img_width (image_width),
    .base      (base_address),
    .done      (addr_done),
    .addr      (addr_value)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  // Next state and address unit launch.
  always_comb begin
    state_next    = state;
    addr_start    = (state == S_ADDR) && !issued;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.data.mode == MODE_START) begin
            state_next = S_ADDR;
          end else if (steps_left <= STEP_W'(1)) begin
            state_next = S_MOD3;
          end else begin
            state_next = S_MOVE;
          end
        end
      end
      S_MOD3: begin
        if (div_done) begin
          state_next = (move_speed == '0) ? S_STEER : S_SPDIV;
        end
      end
      S_SPDIV: begin
        if (div_done) begin
          state_next = (div_quot[IMG_W-1:DIV_SHIFT] == '0) ? S_STEER : S_QMOD;
        end
      end
      S_QMOD: begin
        if (div_done) begin
          state_next = S_STEER;
        end
      end
      S_STEER: state_next = S_MOVE;
      S_MOVE:  state_next = S_ADDR;
      S_ADDR: begin
        if (addr_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    issued_next = (state_next != state) ? 1'b0
                                        : (issued | div_req.start | addr_start);
  end

  // Walk state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x      <= '0;
      offset_y      <= '0;
      direction     <= '0;
      steps_left    <= STEP_W'(1);
      bounce_parity <= 1'b0;
      hit           <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.data.mode == MODE_START) begin
              offset_x      <= ctr_x;
              offset_y      <= ctr_y;
              direction     <= req.data.random_word[DIR_W-1:0];
              steps_left    <= STEP_W'(1);
              bounce_parity <= req.data.random_word[0];
              hit           <= 1'b0;
            end else if (steps_left > STEP_W'(1)) begin
              steps_left <= steps_left - STEP_W'(1);
            end
          end
        end
        S_STEER: begin
          direction     <= direction + DIR_W'(rm3) - DIR_W'(1);
          bounce_parity <= rand_q[Q_SHIFT];
          steps_left    <= new_cnt;
        end
        S_MOVE: begin
          offset_x  <= mv_x;
          offset_y  <= mv_y;
          direction <= mv_dir;
          hit       <= mv_hit;
          if (mv_hit) begin
            steps_left <= STEP_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers: random word, steering remainder, divisor and count.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      rand_q <= req.data.random_word;
    end
    if (state == S_MOD3 && div_done) begin
      rm3 <= div_rem[1:0];
      if (move_speed == '0) begin
        div_q <= '0;
        cnt_q <= STEP_W'(1);
      end
    end
    if (state == S_SPDIV && div_done) begin
      div_q <= div_quot[IMG_W-1:DIV_SHIFT];
      if (div_quot[IMG_W-1:DIV_SHIFT] == '0) begin
        cnt_q <= STEP_W'(1);
      end
    end
    if (state == S_QMOD && div_done) begin
      cnt_q <= div_rem[STEP_W-1:0];
    end
  end

  // Result register; holds an item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && (!rsp_valid || rsp.ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp_valid || rsp.ready)) begin
      rsp_data.window_address <= addr_value;
      rsp_data.window_x       <= offset_x;
      rsp_data.window_y       <= offset_y;
      rsp_data.heading        <= direction;
      rsp_data.edge_hit       <= hit;
    end
  end

  // Checks on the sequencer and the walk state.
  `RWWP_ASSERT_NXT(a_accept_leaves_idle, clk, rst, req.valid && req.ready, state != S_IDLE, "accepted item did not start work")
  `RWWP_ASSERT_IMP(a_steps_nonzero, clk, rst, 1'b1, steps_left != '0, "step count reached zero")
  `RWWP_ASSERT_IMP(a_offset_in_range, clk, rst, state == S_ADDR, offset_x <= lim_x && offset_y <= lim_y, "window offset beyond travel limit")
  `RWWP_ASSERT_IMP(a_hit_rearms, clk, rst, state == S_ADDR && hit, steps_left == STEP_W'(1), "edge hit did not rearm step count")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the random walk window pan block.
`timescale 1ns / 100ps

module tb;
  import rwwp_pkg::*;

  localparam int PHASE_ITEMS   = 125;
  localparam int RANDOM_PHASES = 14;
  localparam int PAUSE_PHASE   = 2;
  localparam int HOLD_PHASE    = 4;
  localparam int LONG_HOLD     = 700;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 8000;
  localparam int REPORT_MAX    = 10;

  // Headings, clockwise from up.
  typedef enum logic [2:0] {
    HEAD_N, HEAD_NE, HEAD_E, HEAD_SE, HEAD_S, HEAD_SW, HEAD_W, HEAD_NW
  } heading_e;

  logic clk;
  logic rst;

  rwwp_stream_if #(.T(in_item_t))  req_if ();
  rwwp_stream_if #(.T(out_item_t)) rsp_if ();
  rwwp_stream_if #(.T(cfg_item_t)) cfg_if ();

  random_walk_window_pan dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // Register copies and walk state of the predictor.
  logic [IMG_W-1:0]   img_w_r;
  logic [IMG_W-1:0]   img_h_r;
  logic [OFFS_W-1:0]  win_w_r;
  logic [OFFS_W-1:0]  win_h_r;
  logic [SPEED_W-1:0] speed_r;
  logic [ADDR_W-1:0]  base_r;
  logic [OFFS_W-1:0]  pos_x;
  logic [OFFS_W-1:0]  pos_y;
  heading_e           dir;
  logic [9:0]         steps;
  logic               parity;

  in_item_t  pending_items[$];
  out_item_t expected_windows[$];

  bit calm;
  int drv_gap;
  int mon_gap;
  int mon_hold;
  int hold_reqs;
  int hold_seen;
  int idle_cycles;
  int items_sent;
  int starts_sent;
  int results_checked;
  int edge_hits;
  int mismatches;
  int failures;
  int settings_count;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Free travel of the window along one axis, held to the offset range.
  function automatic int unsigned free_travel(input int unsigned img, input int unsigned win);
    int unsigned d;
    d = (img > win) ? img - win : 0;
    return (d > 4095) ? 4095 : d;
  endfunction

  // Advances the walk by one item and returns the window it should report.
  function automatic out_item_t predict_window(input in_item_t item);
    out_item_t   res;
    int unsigned rv, iw, ih, ww, wh, spd, lim_x, lim_y, q, dv, cnt, fl, cx, cy;
    int          x, y, sp;
    heading_e    d;
    logic        hit;
    rv    = item.random_word;
    iw    = img_w_r;
    ih    = img_h_r;
    ww    = win_w_r;
    wh    = win_h_r;
    spd   = speed_r;
    lim_x = free_travel(iw, ww);
    lim_y = free_travel(ih, wh);
    hit   = 1'b0;
    if (item.mode == MODE_START) begin
      cx     = (iw > ww) ? (iw - ww) / 2 : 0;
      cy     = (ih > wh) ? (ih - wh) / 2 : 0;
      pos_x  = OFFS_W'((cx > lim_x) ? lim_x : cx);
      pos_y  = OFFS_W'((cy > lim_y) ? lim_y : cy);
      dir    = heading_e'(rv[2:0]);
      steps  = 10'd1;
      parity = rv[0];
    end else begin
      // Segment finished: steer and draw a new step count.
      if (steps <= 1) begin
        q   = rv >> 8;
        dv  = (spd != 0) ? (iw / spd) / 8 : 0;
        cnt = (dv != 0) ? q % dv : 1;
        fl  = (spd > 10) ? 10 : spd;
        dir = heading_e'(3'(int'(dir) + int'(rv % 3) + 7));
        parity = q[0];
        if (cnt == 0) cnt = 1;
        if (cnt < fl) cnt = fl;
        steps = cnt[9:0];
      end else begin
        steps = steps - 10'd1;
      end

      // Move along the heading's axes.
      d  = dir;
      x  = int'(pos_x);
      y  = int'(pos_y);
      sp = int'(spd);
      if (d == HEAD_N || d == HEAD_NE || d == HEAD_NW) y -= sp;
      else if (d == HEAD_SE || d == HEAD_S || d == HEAD_SW) y += sp;
      if (d == HEAD_NE || d == HEAD_E || d == HEAD_SE) x += sp;
      else if (d == HEAD_SW || d == HEAD_W || d == HEAD_NW) x -= sp;

      // Clamp left, top, right, bottom in turn, reflecting the heading.
      if (x < 0) begin
        x = 0;
        hit = 1'b1;
        if (d == HEAD_NW) d = HEAD_N;
        else if (d == HEAD_SW) d = HEAD_S;
        else if (d == HEAD_W) d = parity ? HEAD_N : HEAD_S;
      end
      if (y < 0) begin
        y = 0;
        hit = 1'b1;
        if (d == HEAD_NE) d = HEAD_E;
        else if (d == HEAD_NW) d = HEAD_W;
        else if (d == HEAD_N) d = parity ? HEAD_E : HEAD_W;
      end
      if (x > int'(lim_x)) begin
        x = int'(lim_x);
        hit = 1'b1;
        if (d == HEAD_SE) d = HEAD_S;
        else if (d == HEAD_NE) d = HEAD_N;
        else if (d == HEAD_E) d = parity ? HEAD_S : HEAD_N;
      end
      if (y > int'(lim_y)) begin
        y = int'(lim_y);
        hit = 1'b1;
        if (d == HEAD_SW) d = HEAD_W;
        else if (d == HEAD_SE) d = HEAD_E;
        else if (d == HEAD_S) d = parity ? HEAD_W : HEAD_E;
      end
      if (hit) steps = 10'd1;
      dir   = d;
      pos_x = OFFS_W'(x);
      pos_y = OFFS_W'(y);
    end
    res.window_address = base_r + (ADDR_W'(pos_y) * ADDR_W'(img_w_r) + ADDR_W'(pos_x)) * 4;
    res.window_x = pos_x;
    res.window_y = pos_y;
    res.heading  = dir;
    res.edge_hit = hit;
    return res;
  endfunction

  // Idle cycles a side waits before its next item.
  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [RAND_W-1:0] rand_word();
    return RAND_W'($urandom_range(0, 32'h0FFF_FFFF));
  endfunction

  // Image size: extremes, small images that bounce often, and full range.
  function automatic logic [IMG_W-1:0] pick_image();
    case ($urandom_range(0, 9))
      0: return 13'd2;
      1: return 13'd4096;
      2, 3, 4, 5: return IMG_W'($urandom_range(8, 64));
      6, 7, 8: return IMG_W'($urandom_range(65, 4096));
      default: return IMG_W'($urandom_range(2, 8191));
    endcase
  endfunction

  // Window size, mostly smaller than the image.
  function automatic logic [OFFS_W-1:0] pick_window(input logic [IMG_W-1:0] img);
    int unsigned top;
    top = (img > 1) ? img - 1 : 1;
    if (top > 4095) top = 4095;
    case ($urandom_range(0, 9))
      0: return 12'd1;
      1: return 12'd4095;
      2: return OFFS_W'($urandom_range(1, 4095));
      default: return OFFS_W'($urandom_range(1, top));
    endcase
  endfunction

  task automatic queue_item(input logic mode, input logic [RAND_W-1:0] word);
    in_item_t item;
    item.mode = mode;
    item.random_word = word;
    pending_items.push_back(item);
  endtask

  // One register write; valid is left high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    cfg_item_t w;
    w.index = idx;
    w.value = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    case (idx)
      REG_IMAGE_WIDTH:   img_w_r = val[IMG_W-1:0];
      REG_IMAGE_HEIGHT:  img_h_r = val[IMG_W-1:0];
      REG_WINDOW_WIDTH:  win_w_r = val[OFFS_W-1:0];
      REG_WINDOW_HEIGHT: win_h_r = val[OFFS_W-1:0];
      REG_MOVE_SPEED:    speed_r = val[SPEED_W-1:0];
      REG_BASE_ADDRESS:  base_r  = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [IMG_W-1:0] iw, input logic [IMG_W-1:0] ih,
                              input logic [OFFS_W-1:0] ww, input logic [OFFS_W-1:0] wh,
                              input logic [SPEED_W-1:0] spd, input logic [ADDR_W-1:0] base);
    write_reg(REG_IMAGE_WIDTH, ADDR_W'(iw));
    write_reg(REG_IMAGE_HEIGHT, ADDR_W'(ih));
    write_reg(REG_WINDOW_WIDTH, ADDR_W'(ww));
    write_reg(REG_WINDOW_HEIGHT, ADDR_W'(wh));
    write_reg(REG_MOVE_SPEED, ADDR_W'(spd));
    write_reg(REG_BASE_ADDRESS, base);
    cfg_if.valid <= 1'b0;
    settings_count++;
  endtask

  // Waits until every queued item is taken and answered, then lets the block settle.
  task automatic wait_drained();
    while (pending_items.size() != 0 || req_if.valid || expected_windows.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request driver: offers the oldest pending item after a random gap.
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_windows.push_back(predict_window(req_if.data));
        items_sent++;
        if (req_if.data.mode == MODE_START) starts_sent++;
        void'(pending_items.pop_front());
        drv_gap = idle_draw();
      end
      if (!req_if.valid || req_if.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_items[0];
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      mon_gap = 0;
      mon_hold = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        results_checked++;
        if (expected_windows.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result addr=%h x=%0d y=%0d heading=%0d hit=%0b",
                     $realtime, got.window_address, got.window_x, got.window_y,
                     got.heading, got.edge_hit);
        end else begin
          want = expected_windows.pop_front();
          if (want.edge_hit) edge_hits++;
          if (got.window_address !== want.window_address || got.window_x !== want.window_x ||
              got.window_y !== want.window_y || got.heading !== want.heading ||
              got.edge_hit !== want.edge_hit) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: mismatch exp addr=%h x=%0d y=%0d hd=%0d hit=%0b, got addr=%h x=%0d y=%0d hd=%0d hit=%0b",
                       $realtime, want.window_address, want.window_x, want.window_y,
                       want.heading, want.edge_hit, got.window_address, got.window_x,
                       got.window_y, got.heading, got.edge_hit);
          end
        end
        mon_gap = idle_draw();
      end
      if (hold_seen != hold_reqs) begin
        hold_seen++;
        mon_hold = LONG_HOLD;
      end
      if (mon_hold > 0) begin
        mon_hold--;
        rsp_if.ready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no channel moves an item for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $realtime, STALL_LIMIT, expected_windows.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    logic [IMG_W-1:0]   iw, ih;
    logic [OFFS_W-1:0]  ww, wh;
    logic [SPEED_W-1:0] spd;
    logic [ADDR_W-1:0]  base;

    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    calm = 1'b0;
    img_w_r = IMAGE_WIDTH_RST;
    img_h_r = IMAGE_HEIGHT_RST;
    win_w_r = WINDOW_WIDTH_RST;
    win_h_r = WINDOW_HEIGHT_RST;
    speed_r = MOVE_SPEED_RST;
    base_r  = BASE_ADDRESS_RST;
    pos_x   = '0;
    pos_y   = '0;
    dir     = HEAD_N;
    steps   = 10'd1;
    parity  = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // Reset settings: a tick straight out of reset, then starts and ticks
    // with extreme random words.
    queue_item(MODE_TICK, 28'h0000003);
    queue_item(MODE_START, 28'h0000000);
    queue_item(MODE_TICK, 28'h0000000);
    queue_item(MODE_TICK, 28'hFFFFFFF);
    queue_item(MODE_START, 28'hFFFFFFF);
    queue_item(MODE_TICK, 28'h0000001);
    queue_item(MODE_TICK, 28'h0000002);
    queue_item(MODE_TICK, 28'h5555555);
    wait_drained();

    // Smallest image at top speed: the step count divisor is zero.
    program_regs(13'd2, 13'd2, 12'd1, 12'd1, 8'd255, 32'hFFFF_FFFF);
    queue_item(MODE_START, 28'h0000003);
    queue_item(MODE_TICK, 28'h0000000);
    queue_item(MODE_TICK, 28'h0000001);
    queue_item(MODE_TICK, 28'h0000002);
    queue_item(MODE_TICK, 28'hAAAAAAA);
    wait_drained();

    // Zero speed, an image narrower than its window, and a travel that
    // saturates the offset range.
    program_regs(13'd100, 13'd8191, 12'd200, 12'd0, 8'd0, 32'h1234_5678);
    queue_item(MODE_START, 28'h0000006);
    queue_item(MODE_TICK, 28'h0000007);
    queue_item(MODE_TICK, 28'hFFFFF00);
    wait_drained();

    // Small image: straight-on hits at the edges with either parity.
    program_regs(13'd20, 13'd20, 12'd10, 12'd10, 8'd6, 32'h0000_0100);
    queue_item(MODE_START, 28'h0000002);
    queue_item(MODE_TICK, 28'h0000001);
    queue_item(MODE_TICK, 28'h0000100);
    queue_item(MODE_START, 28'h0000007);
    queue_item(MODE_TICK, 28'h0000301);

    // Random phases: a start followed by a long walk, with stray starts
    // and now and then a walk that continues from the previous settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      if (p == 0) begin
        program_regs(13'd4096, 13'd4096, 12'd1, 12'd4095, 8'd10, 32'h8000_0000);
      end else begin
        iw = pick_image();
        ih = pick_image();
        ww = pick_window(iw);
        wh = pick_window(ih);
        case ($urandom_range(0, 11))
          0: spd = 8'd0;
          1: spd = 8'd1;
          2: spd = 8'd255;
          3, 4, 5: spd = SPEED_W'($urandom_range(1, 12));
          default: spd = SPEED_W'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 5))
          0: base = 32'h0000_0000;
          1: base = 32'hFFFF_FFFF;
          default: base = $urandom;
        endcase
        program_regs(iw, ih, ww, wh, spd, base);
      end
      calm = (p != HOLD_PHASE) && ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) != 0) queue_item(MODE_START, rand_word());
      // The receiver holds off while the sender keeps offering.
      if (p == HOLD_PHASE) hold_reqs++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // The sender pauses until every result so far is in.
        if (p == PAUSE_PHASE && i == PHASE_ITEMS / 2) wait_drained();
        queue_item(($urandom_range(0, 24) == 0) ? MODE_START : MODE_TICK, rand_word());
      end
    end

    // Drain and finish.
    wait_drained();
    failures = mismatches + expected_windows.size();
    $display("Walked %0d items (%0d starts) over %0d register settings plus reset values.",
             items_sent, starts_sent, settings_count);
    $display("Checked %0d results, %0d clamped at an edge, %0d mismatches.",
             results_checked, edge_hits, mismatches);
    if (failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
